// ----- rtl/gelv_pkg.sv -----
// Shared types and constants for the least-visited grid explorer.
`default_nettype none

package gelv_pkg;

  // Grid geometry is tied to the 2-bit coordinate fields and the 16-bit obstacle map
  localparam int GRID_SIZE = 4;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;

  typedef logic [1:0] coord_t;
  typedef logic [3:0] cell_t;

  // Neighbour directions, also the bit order of the new-found mask
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Tie-break order for the move choice
  localparam dir_t MOVE_ORDER [4] = '{DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT};

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_OBSTACLE_MAP = 2'd0,
    REG_TARGET_FOUND = 2'd1,
    REG_START_ROW    = 2'd2,
    REG_START_COL    = 2'd3
  } reg_idx_t;

  localparam logic [15:0] OBSTACLE_MAP_RST = 16'h4012;
  localparam logic [3:0]  TARGET_FOUND_RST = 4'd3;
  localparam coord_t      START_ROW_RST    = 2'd3;
  localparam coord_t      START_COL_RST    = 2'd0;

  // One result item
  typedef struct packed {
    coord_t     from_row;
    coord_t     from_col;
    coord_t     to_row;
    coord_t     to_col;
    logic [3:0] new_found_mask;
    logic [3:0] found_total;
    logic       done_res;
    logic       stuck;
  } res_t;

  // State update requested by the step logic for a normal (not done) step
  typedef struct packed {
    logic             advance;
    coord_t           next_row;
    coord_t           next_col;
    logic [CELLS-1:0] found_add;
  } upd_t;

endpackage

`default_nettype wire

// ----- rtl/gelv_step.sv -----
// Combinational step logic: obstacle recording and least-visited move choice.
`default_nettype none

module gelv_step #(
  parameter int MAX_FOUND   = 8,
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic                                        restart,
  input  wire gelv_pkg::coord_t                            cur_row,
  input  wire gelv_pkg::coord_t                            cur_col,
  input  wire gelv_pkg::coord_t                            start_row,
  input  wire gelv_pkg::coord_t                            start_col,
  input  wire logic [15:0]                                 obstacle_map,
  input  wire logic [3:0]                                  target_found,
  input  wire logic [gelv_pkg::CELLS-1:0]                  found_set,
  input  wire logic [$clog2(MAX_FOUND+1)-1:0]              found_cnt,
  input  wire logic [gelv_pkg::CELLS-1:0][COUNT_WIDTH-1:0] counts,
  output gelv_pkg::res_t                                   res,
  output gelv_pkg::upd_t                                   upd,
  output logic [$clog2(MAX_FOUND+1)-1:0]                   found_cnt_nxt
);

  localparam int FCW = $clog2(MAX_FOUND + 1);
  localparam logic [FCW+2:0] MAX_W = (FCW + 3)'(MAX_FOUND);

  gelv_pkg::coord_t nb_row [4];
  gelv_pkg::coord_t nb_col [4];
  gelv_pkg::cell_t  nb_cell [4];
  logic [3:0]       nb_in;
  logic [3:0]       obst;
  logic [3:0]       cand;
  logic [3:0]       rec;
  logic [3:0]       free;
  logic [COUNT_WIDTH-1:0] nb_cnt [4];
  logic             done;
  logic             step_on;
  logic [FCW+2:0]   slot;
  logic             best_found;
  logic [COUNT_WIDTH-1:0] best_cnt;
  gelv_pkg::dir_t   best_dir;

  // Neighbour coordinates; off-grid ones are masked by nb_in
  assign nb_row[gelv_pkg::DIR_UP]    = cur_row - 2'd1;
  assign nb_col[gelv_pkg::DIR_UP]    = cur_col;
  assign nb_row[gelv_pkg::DIR_DOWN]  = cur_row + 2'd1;
  assign nb_col[gelv_pkg::DIR_DOWN]  = cur_col;
  assign nb_row[gelv_pkg::DIR_LEFT]  = cur_row;
  assign nb_col[gelv_pkg::DIR_LEFT]  = cur_col - 2'd1;
  assign nb_row[gelv_pkg::DIR_RIGHT] = cur_row;
  assign nb_col[gelv_pkg::DIR_RIGHT] = cur_col + 2'd1;

  assign nb_in[gelv_pkg::DIR_UP]    = (cur_row != 2'd0);
  assign nb_in[gelv_pkg::DIR_DOWN]  = (cur_row != 2'(gelv_pkg::GRID_SIZE - 1));
  assign nb_in[gelv_pkg::DIR_LEFT]  = (cur_col != 2'd0);
  assign nb_in[gelv_pkg::DIR_RIGHT] = (cur_col != 2'(gelv_pkg::GRID_SIZE - 1));

  // Per-neighbour lookups
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nb_cell[d] = {nb_row[d], nb_col[d]};
      obst[d]    = obstacle_map[nb_cell[d]];
      nb_cnt[d]  = counts[nb_cell[d]];
      cand[d]    = nb_in[d] && obst[d] && !found_set[nb_cell[d]];
      free[d]    = nb_in[d] && !obst[d];
    end
  end

  assign done    = ((FCW + 4)'(found_cnt) == (FCW + 4)'(target_found));
  assign step_on = !restart && !done;

  // Record new obstacles in direction order until the list is full
  always_comb begin
    slot = (FCW + 3)'(found_cnt);
    rec  = '0;
    for (int d = 0; d < 4; d++) begin
      if (cand[d] && (slot < MAX_W)) begin
        rec[d] = 1'b1;
        slot   = slot + (FCW + 3)'(1);
      end
    end
    found_cnt_nxt = FCW'(slot);
  end

  // Fewest visits wins; strict compare keeps the earlier direction on a tie
  always_comb begin
    best_found = 1'b0;
    best_cnt   = '0;
    best_dir   = gelv_pkg::DIR_UP;
    for (int i = 0; i < 4; i++) begin
      if (free[gelv_pkg::MOVE_ORDER[i]] &&
          (!best_found || (nb_cnt[gelv_pkg::MOVE_ORDER[i]] < best_cnt))) begin
        best_found = 1'b1;
        best_cnt   = nb_cnt[gelv_pkg::MOVE_ORDER[i]];
        best_dir   = gelv_pkg::MOVE_ORDER[i];
      end
    end
  end

  // State update for a normal step
  always_comb begin
    upd.advance   = step_on;
    upd.next_row  = best_found ? nb_row[best_dir] : cur_row;
    upd.next_col  = best_found ? nb_col[best_dir] : cur_col;
    upd.found_add = '0;
    for (int d = 0; d < 4; d++) begin
      if (rec[d]) begin
        upd.found_add[nb_cell[d]] = 1'b1;
      end
    end
  end

  // Result item
  always_comb begin
    res.from_row       = cur_row;
    res.from_col       = cur_col;
    res.to_row         = cur_row;
    res.to_col         = cur_col;
    res.new_found_mask = '0;
    res.found_total    = 4'(found_cnt);
    res.done_res       = 1'b0;
    res.stuck          = 1'b0;
    if (restart) begin
      res.to_row      = start_row;
      res.to_col      = start_col;
      res.found_total = '0;
    end else if (done) begin
      res.done_res = 1'b1;
    end else begin
      res.to_row         = upd.next_row;
      res.to_col         = upd.next_col;
      res.new_found_mask = rec;
      res.found_total    = 4'(found_cnt_nxt);
      res.stuck          = !best_found;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/grid_explorer_least_visited_core.sv -----
// Top level of the least-visited grid explorer: state, config and output skid.
//
// A robot walks a 4x4 grid whose obstacles come from obstacle_map. Each item
// with restart=0 takes one step (or reports done once the found count equals
// target_found); restart=1 clears visit counts and the found list and loads
// the start cell. One result item per input item. Each item is worked out
// combinationally from the state registers and lands in the output register
// or skid entry, so an item can be accepted every cycle while in_stall is low.
// A two-entry output (register plus skid) keeps input accepted while one
// result waits; in_stall rises only when both entries are full. Configuration
// writes take effect at once and should only be made while no item is in flight.
`default_nettype none

module grid_explorer_least_visited_core #(
  parameter int MAX_FOUND   = 8,
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_restart,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_from_row,
  output logic [1:0]       out_from_col,
  output logic [1:0]       out_to_row,
  output logic [1:0]       out_to_col,
  output logic [3:0]       out_new_found_mask,
  output logic [3:0]       out_found_total,
  output logic             out_done_res,
  output logic             out_stuck
);

  localparam int FCW = $clog2(MAX_FOUND + 1);
  localparam int CELLS = gelv_pkg::CELLS;

  // configuration registers
  logic [15:0]      obstacle_map_r;
  logic [3:0]       target_found_r;
  gelv_pkg::coord_t start_row_r;
  gelv_pkg::coord_t start_col_r;

  // walk state
  gelv_pkg::coord_t                    cur_row_r, cur_row_nxt;
  gelv_pkg::coord_t                    cur_col_r, cur_col_nxt;
  logic [CELLS-1:0][COUNT_WIDTH-1:0]   counts_r, counts_nxt;
  logic [CELLS-1:0]                    found_set_r, found_set_nxt;
  logic [FCW-1:0]                      found_cnt_r, found_cnt_nxt;

  // output stage
  gelv_pkg::res_t out_r, out_nxt;
  gelv_pkg::res_t skid_r, skid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;

  gelv_pkg::res_t   step_res;
  gelv_pkg::upd_t   step_upd;
  logic [FCW-1:0]   step_cnt;
  logic             in_accept;
  logic             out_free;
  gelv_pkg::cell_t  here;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign here      = {cur_row_r, cur_col_r};

  gelv_step #(
    .MAX_FOUND   (MAX_FOUND),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .restart       (in_restart),
    .cur_row       (cur_row_r),
    .cur_col       (cur_col_r),
    .start_row     (start_row_r),
    .start_col     (start_col_r),
    .obstacle_map  (obstacle_map_r),
    .target_found  (target_found_r),
    .found_set     (found_set_r),
    .found_cnt     (found_cnt_r),
    .counts        (counts_r),
    .res           (step_res),
    .upd           (step_upd),
    .found_cnt_nxt (step_cnt)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_map_r <= gelv_pkg::OBSTACLE_MAP_RST;
      target_found_r <= gelv_pkg::TARGET_FOUND_RST;
      start_row_r    <= gelv_pkg::START_ROW_RST;
      start_col_r    <= gelv_pkg::START_COL_RST;
    end else if (cfg_we) begin
      unique case (gelv_pkg::reg_idx_t'(cfg_index))
        gelv_pkg::REG_OBSTACLE_MAP: obstacle_map_r <= cfg_data;
        gelv_pkg::REG_TARGET_FOUND: target_found_r <= cfg_data[3:0];
        gelv_pkg::REG_START_ROW:    start_row_r    <= cfg_data[1:0];
        gelv_pkg::REG_START_COL:    start_col_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // walk state update on an accepted item
  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    counts_nxt    = counts_r;
    found_set_nxt = found_set_r;
    found_cnt_nxt = found_cnt_r;
    if (in_accept) begin
      if (in_restart) begin
        cur_row_nxt   = start_row_r;
        cur_col_nxt   = start_col_r;
        counts_nxt    = '0;
        found_set_nxt = '0;
        found_cnt_nxt = '0;
      end else if (step_upd.advance) begin
        cur_row_nxt   = step_upd.next_row;
        cur_col_nxt   = step_upd.next_col;
        found_set_nxt = found_set_r | step_upd.found_add;
        found_cnt_nxt = step_cnt;
        // saturating visit count of the cell being left
        if (counts_r[here] != '1) begin
          counts_nxt[here] = counts_r[here] + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= gelv_pkg::START_ROW_RST;
      cur_col_r   <= gelv_pkg::START_COL_RST;
      counts_r    <= '0;
      found_set_r <= '0;
      found_cnt_r <= '0;
    end else begin
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      counts_r    <= counts_nxt;
      found_set_r <= found_set_nxt;
      found_cnt_r <= found_cnt_nxt;
    end
  end

  // output register with skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_accept) begin
        out_nxt       = step_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_accept) begin
      skid_nxt       = step_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_from_row       = out_r.from_row;
  assign out_from_col       = out_r.from_col;
  assign out_to_row         = out_r.to_row;
  assign out_to_col         = out_r.to_col;
  assign out_new_found_mask = out_r.new_found_mask;
  assign out_found_total    = out_r.found_total;
  assign out_done_res       = out_r.done_res;
  assign out_stuck          = out_r.stuck;

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // found list never grows past its capacity
  a_found_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (FCW + 1)'(found_cnt_r) <= (FCW + 1)'(MAX_FOUND))
    else $error("found count above capacity");

  // a restart empties the found list
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_restart) |=> (found_cnt_r == '0) && (found_set_r == '0))
    else $error("found list not cleared by restart");

  // a result is never both done and stuck
  a_done_not_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.done_res && out_r.stuck))
    else $error("result flagged done and stuck");

endmodule

`default_nettype wire
